// ===== src/pidr_pkg.sv =====
// Package: register map, configuration struct and reset values of the PID duty regulator.
package pidr_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_ENABLE    = 3'd1;
    localparam logic [2:0] REG_KP        = 3'd2;
    localparam logic [2:0] REG_KI        = 3'd3;
    localparam logic [2:0] REG_KD        = 3'd4;
    localparam logic [2:0] REG_ILIMIT    = 3'd5;
    localparam logic [2:0] REG_DLIMIT    = 3'd6;

    localparam logic [20:0] TARGET_MAX   = 21'd1966080;

    localparam logic [23:0] KP_RESET     = 24'd838861;
    localparam logic [23:0] KI_RESET     = 24'd336;
    localparam logic [27:0] KD_RESET     = 28'd167772160;
    localparam logic [30:0] ILIMIT_RESET = 31'd1288490189;
    localparam logic [15:0] DLIMIT_RESET = 16'd62259;

    typedef struct packed {
        logic [20:0] target_voltage;
        logic        enable;
        logic [23:0] kp_gain;
        logic [23:0] ki_gain;
        logic [27:0] kd_gain;
        logic [30:0] integral_limit;
        logic [15:0] duty_limit;
    } cfg_t;

endpackage

// ===== src/pidr_cfg.sv =====
// APB register bank holding the regulator setpoint, enable, gains and limits.
module pidr_cfg
    import pidr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  idx;
    logic [20:0] target_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    assign target_next = (pwdata[20:0] > TARGET_MAX) ? TARGET_MAX : pwdata[20:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_voltage <= '0;
            cfg_reg.enable         <= 1'b0;
            cfg_reg.kp_gain        <= KP_RESET;
            cfg_reg.ki_gain        <= KI_RESET;
            cfg_reg.kd_gain        <= KD_RESET;
            cfg_reg.integral_limit <= ILIMIT_RESET;
            cfg_reg.duty_limit     <= DLIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TARGET: cfg_reg.target_voltage <= target_next;
                REG_ENABLE: cfg_reg.enable         <= pwdata[0];
                REG_KP:     cfg_reg.kp_gain        <= pwdata[23:0];
                REG_KI:     cfg_reg.ki_gain        <= pwdata[23:0];
                REG_KD:     cfg_reg.kd_gain        <= pwdata[27:0];
                REG_ILIMIT: cfg_reg.integral_limit <= pwdata[30:0];
                REG_DLIMIT: cfg_reg.duty_limit     <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TARGET: prdata = {11'd0, cfg_reg.target_voltage};
            REG_ENABLE: prdata = {31'd0, cfg_reg.enable};
            REG_KP:     prdata = {8'd0, cfg_reg.kp_gain};
            REG_KI:     prdata = {8'd0, cfg_reg.ki_gain};
            REG_KD:     prdata = {4'd0, cfg_reg.kd_gain};
            REG_ILIMIT: prdata = {1'b0, cfg_reg.integral_limit};
            REG_DLIMIT: prdata = {16'd0, cfg_reg.duty_limit};
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== src/pidr_core.sv =====
// Six-stage PID pipeline: error, gain products, integral clamp, duty clamp, compare count.
module pidr_core
    import pidr_pkg::*;
#(
    parameter int PWM_PERIOD = 3400
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [22:0] in_meas,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_duty,
    output logic [11:0] out_cmp
);

    localparam int NST = 6;
    localparam logic [15:0] PERIOD_W = 16'(PWM_PERIOD);

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] ld;

    // stage payload
    logic        [22:0] meas_reg;
    logic signed [23:0] err_reg;
    logic signed [24:0] diff_reg;
    logic signed [40:0] p_reg;
    logic signed [40:0] kit_reg;
    logic signed [45:0] d_reg;
    logic signed [31:0] i_reg;
    logic signed [46:0] pd_reg;
    logic        [15:0] duty_reg;
    logic        [15:0] duty_out_reg;
    logic        [11:0] cmp_reg;

    // regulator state
    logic signed [23:0] last_err_reg;
    logic signed [31:0] integral_reg;

    logic signed [23:0] err_next;
    logic signed [24:0] diff_next;
    logic signed [48:0] p_full;
    logic signed [48:0] ki_full;
    logic signed [53:0] d_full;
    logic signed [41:0] i_sum;
    logic signed [41:0] lim_pos;
    logic signed [41:0] lim_neg;
    logic signed [31:0] i_next;
    logic signed [46:0] pd_next;
    logic signed [47:0] sum;
    logic        [31:0] quot;
    logic        [15:0] duty_next;
    logic        [31:0] cmp_full;

    // ready chain
    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[0] = rdy[0] && in_valid;
        for (int k = 1; k < NST; k++)
        begin
            ld[k] = rdy[k] && vld_reg[k-1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign out_duty  = duty_out_reg;
    assign out_cmp   = cmp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: error and error difference
    assign err_next  = $signed({3'b000, cfg.target_voltage}) - $signed({meas_reg[22], meas_reg});
    assign diff_next = $signed({err_next[23], err_next}) - $signed({last_err_reg[23], last_err_reg});

    // stage 2: gain products, floor shift by 8
    assign p_full  = $signed({1'b0, cfg.kp_gain}) * err_reg;
    assign ki_full = $signed({1'b0, cfg.ki_gain}) * err_reg;
    assign d_full  = $signed({1'b0, cfg.kd_gain}) * diff_reg;

    // stage 3: integral with anti-windup clamp, P + D
    assign i_sum   = $signed({{10{integral_reg[31]}}, integral_reg}) + $signed({kit_reg[40], kit_reg});
    assign lim_pos = $signed({11'd0, cfg.integral_limit});
    assign lim_neg = -lim_pos;
    always_comb
    begin
        if (i_sum > lim_pos)
        begin
            i_next = lim_pos[31:0];
        end
        else if (i_sum < lim_neg)
        begin
            i_next = lim_neg[31:0];
        end
        else
        begin
            i_next = i_sum[31:0];
        end
    end
    assign pd_next = $signed({d_reg[45], d_reg}) + $signed({{6{p_reg[40]}}, p_reg});

    // stage 4: total, zeroed when disabled or not positive, and duty clamp
    assign sum  = $signed({pd_reg[46], pd_reg}) + $signed({{16{i_reg[31]}}, i_reg});
    assign quot = sum[47:16];
    always_comb
    begin
        if (!cfg.enable || sum[47] || (sum == '0))
        begin
            duty_next = '0;
        end
        else if (quot > {16'd0, cfg.duty_limit})
        begin
            duty_next = cfg.duty_limit;
        end
        else
        begin
            duty_next = quot[15:0];
        end
    end

    // stage 5: compare count
    assign cmp_full = duty_reg * PERIOD_W;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            meas_reg <= in_meas;
        end
        if (ld[1])
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
        if (ld[2])
        begin
            p_reg   <= p_full[48:8];
            kit_reg <= ki_full[48:8];
            d_reg   <= d_full[53:8];
        end
        if (ld[3])
        begin
            i_reg  <= i_next;
            pd_reg <= pd_next;
        end
        if (ld[4])
        begin
            duty_reg <= duty_next;
        end
        if (ld[5])
        begin
            duty_out_reg <= duty_reg;
            cmp_reg      <= cmp_full[27:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            integral_reg <= '0;
        end
        else
        begin
            if (ld[1] && cfg.enable)
            begin
                last_err_reg <= err_next;
            end
            if (ld[3] && cfg.enable)
            begin
                integral_reg <= i_next;
            end
        end
    end

endmodule

// ===== src/pid_duty_regulator.sv =====
// PID duty regulator top level: APB register bank and streaming PID pipeline.
// Pipeline: six pipeline registers, the first one capturing the input.
// Throughput: one transaction per cycle while m_tready stays high;
// each stage holds only while the one after it stalls.
// Reset: rst_n asynchronous, active low; clears pipeline valids, integral and last error,
// and loads the register defaults.
module pid_duty_regulator
    import pidr_pkg::*;
#(
    parameter int PWM_PERIOD = 3400
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // [22:0] measured_voltage
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [15:0] duty_cycle, [27:16] compare_count
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t        cfg;
    logic [15:0] duty;
    logic [11:0] cmp;

    pidr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidr_core #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_meas   (s_tdata[22:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_duty  (duty),
        .out_cmp   (cmp)
    );

    assign m_tdata = {4'd0, cmp, duty};

endmodule
